FILE: hdl/svt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types and codes of the sorted value table.
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic ins;
    logic del;
  } svt_cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/svt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svt_cell
// One table slot: compares its entry with the operand and shifts with its
// neighbors on insert and erase.
// ----------------------------------------------------------------------------
module svt_cell
  import svt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  input  wire logic                valid_i,
  input  wire logic                left_lt_i,
  input  wire logic [VALUE_W-1:0]  left_entry_i,
  input  wire logic [VALUE_W-1:0]  right_entry_i,
  input  wire svt_cell_ctl_t       ctl_i,
  output logic      [VALUE_W-1:0]  entry_o,
  output logic                     lt_o,
  output logic                     eq_o
);

  logic [VALUE_W-1:0] entry_q;
  logic [VALUE_W-1:0] entry_d;

  assign lt_o    = valid_i && ($signed(entry_q) < $signed(value_i));
  assign eq_o    = (entry_q == value_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && !lt_o) begin
      entry_d = left_lt_i ? value_i : left_entry_i;
    end else if (ctl_i.del && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

FILE: hdl/sorted_value_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_value_table_unit
// Ascending table of signed values with insert, erase and find.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_stall_o  mode_i, value_i
// out      out  out_valid_o/out_stall_i status_o, result_value_o,
//                                      result_present_o, entry_count_o
//
// A transaction is evaluated in the cycle after acceptance while the cell row
// compares and shifts, and its result is registered when evaluation completes;
// one per cycle sustained while the output drains, since a new transaction
// enters as one retires.
// The row's compare plus one-hot result select forms the registered result.
// Reset clears the count and control only; slots hold no reset value.
// A stalled output holds the pending transaction in its evaluation stage.
// ----------------------------------------------------------------------------
module sorted_value_table_unit
  import svt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [VALUE_W-1:0]  result_value_o,
  output logic                     result_present_o,
  output logic      [COUNT_W-1:0]  entry_count_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic                state_q, state_d;
  logic [MODE_W-1:0]   mode_q;
  logic [VALUE_W-1:0]  value_q;
  logic [CntW-1:0]     count_q, count_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0]  rv_q, rv_d;
  logic                present_q, present_d;
  logic [CntW-1:0]     cnt_out_q;

  logic accept, fire, full, is_ins, is_del, found, nxt_present;
  logic [VALUE_W-1:0] nxt_value;
  svt_cell_ctl_t      ctl;

  logic [VALUE_W-1:0]  entry  [CAPACITY];
  logic [CAPACITY-1:0] lt, eq, valid, bnd;
  logic [CAPACITY-1:0] hit_sel, nxt_sel;
  logic [VALUE_W-1:0]  nxt_cand [CAPACITY];

  assign fire       = (state_q == ST_EVAL) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q == ST_EVAL) && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign full   = (count_q >= CapCnt);
  assign is_ins = (mode_q == MODE_INSERT);
  assign is_del = (mode_q == MODE_ERASE);

  assign ctl.ins = fire && is_ins && !full;
  assign ctl.del = fire && is_del && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic                left_lt;
    logic [VALUE_W-1:0]  left_entry, right_entry;

    assign valid[i] = (Idx < count_q);

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = value_q;
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry[i];
      assign nxt_sel[i]  = 1'b0;
      assign nxt_cand[i] = '0;
    end else begin : g_inner
      assign right_entry = entry[i+1];
      assign nxt_sel[i]  = bnd[i] && valid[i+1];
      assign nxt_cand[i] = nxt_sel[i] ? entry[i+1] : '0;
    end

    assign bnd[i]     = !lt[i] && left_lt;
    assign hit_sel[i] = bnd[i] && valid[i] && eq[i];

    svt_cell u_cell (
      .clk_i         (clk_i),
      .value_i       (value_q),
      .valid_i       (valid[i]),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .ctl_i         (ctl),
      .entry_o       (entry[i]),
      .lt_o          (lt[i]),
      .eq_o          (eq[i])
    );
  end

  assign found       = |hit_sel;
  assign nxt_present = |nxt_sel;

  always_comb begin
    nxt_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      nxt_value = nxt_value | nxt_cand[i];
    end
  end

  always_comb begin
    count_d   = count_q;
    status_d  = STATUS_DONE;
    rv_d      = '0;
    present_d = 1'b0;
    if (is_ins) begin
      rv_d = value_q;
      if (full) begin
        status_d = STATUS_FULL;
      end else begin
        present_d = 1'b1;
        count_d   = count_q + CntW'(1);
      end
    end else if (is_del) begin
      if (found) begin
        count_d   = count_q - CntW'(1);
        rv_d      = nxt_value;
        present_d = nxt_present;
      end else begin
        status_d = STATUS_MISS;
      end
    end else begin
      if (found) begin
        rv_d      = value_q;
        present_d = 1'b1;
      end else begin
        status_d = STATUS_MISS;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_EVAL;
    end else if (fire) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
    if (fire) begin
      status_q  <= status_d;
      rv_q      <= rv_d;
      present_q <= present_d;
      cnt_out_q <= count_d;
    end
  end

  logic [CntW+COUNT_W-1:0] cnt_ext;
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_out_q};

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign result_value_o   = rv_q;
  assign result_present_o = present_q;
  assign entry_count_o    = cnt_ext[COUNT_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/svt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svt_checker
// Port-level checks of the sorted value table, bound to the top level.
// ----------------------------------------------------------------------------
module svt_checker
  import svt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [VALUE_W-1:0]  result_value_o,
  input wire logic                result_present_o,
  input wire logic [COUNT_W-1:0]  entry_count_o
);

  localparam logic [COUNT_W-1:0] CapOut = COUNT_W'(CAPACITY);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o)
      && $stable(status_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL) |-> entry_count_o == CapOut
      && !result_present_o)
    else $error("refused insert with table not full");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_MISS) |-> result_value_o == '0
      && !result_present_o)
    else $error("miss carries a value");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 31) || (entry_count_o <= CapOut))
    else $error("entry count above capacity");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o || !$past(in_stall_o))
    else $error("input stalled with empty output");

endmodule

bind sorted_value_table_unit svt_checker #(.CAPACITY(CAPACITY)) u_svt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .result_value_o   (result_value_o),
  .result_present_o (result_present_o),
  .entry_count_o    (entry_count_o)
);
`default_nettype wire
